### rtl/core/gga_pkg.sv
package gga_pkg;

  // frame buffer limit and position counter width
  localparam int MAX_FRAME = 128;
  localparam int POS_W     = $clog2(MAX_FRAME);

  // field widths
  localparam int BYTE_W  = 8;
  localparam int TWO_W   = 7;
  localparam int SEC_W   = 17;
  localparam int ARCS_W  = 16;
  localparam int FRAC_W  = 14;
  localparam int LOND_W  = 10;

  // characters
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
  localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UA     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UF     = 8'h46;
  localparam logic [BYTE_W-1:0] CH_LA     = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h66;

  // character positions within a frame, '$' at zero
  localparam logic [POS_W-1:0] P_HDR_1      = POS_W'(1);
  localparam logic [POS_W-1:0] P_HDR_2      = POS_W'(2);
  localparam logic [POS_W-1:0] P_HDR_3      = POS_W'(3);
  localparam logic [POS_W-1:0] P_HDR_4      = POS_W'(4);
  localparam logic [POS_W-1:0] P_HDR_5      = POS_W'(5);
  localparam logic [POS_W-1:0] P_HOUR_HI    = POS_W'(7);
  localparam logic [POS_W-1:0] P_HOUR_LO    = POS_W'(8);
  localparam logic [POS_W-1:0] P_MIN_HI     = POS_W'(9);
  localparam logic [POS_W-1:0] P_MIN_LO     = POS_W'(10);
  localparam logic [POS_W-1:0] P_SEC_HI     = POS_W'(11);
  localparam logic [POS_W-1:0] P_SEC_LO     = POS_W'(12);
  localparam logic [POS_W-1:0] P_SEC_DOT    = POS_W'(13);
  localparam logic [POS_W-1:0] P_SEC_F1     = POS_W'(14);
  localparam logic [POS_W-1:0] P_SEC_F2     = POS_W'(15);
  localparam logic [POS_W-1:0] P_SEC_F3     = POS_W'(16);
  localparam logic [POS_W-1:0] P_LAT_DEG_HI = POS_W'(18);
  localparam logic [POS_W-1:0] P_LAT_DEG_LO = POS_W'(19);
  localparam logic [POS_W-1:0] P_LAT_MIN_HI = POS_W'(20);
  localparam logic [POS_W-1:0] P_LAT_MIN_LO = POS_W'(21);
  localparam logic [POS_W-1:0] P_LAT_DOT    = POS_W'(22);
  localparam logic [POS_W-1:0] P_LAT_F1     = POS_W'(23);
  localparam logic [POS_W-1:0] P_LAT_F2     = POS_W'(24);
  localparam logic [POS_W-1:0] P_LAT_F3     = POS_W'(25);
  localparam logic [POS_W-1:0] P_LAT_F4     = POS_W'(26);
  localparam logic [POS_W-1:0] P_LAT_HEMI   = POS_W'(28);
  localparam logic [POS_W-1:0] P_LON_DEG_0  = POS_W'(30);
  localparam logic [POS_W-1:0] P_LON_DEG_1  = POS_W'(31);
  localparam logic [POS_W-1:0] P_LON_DEG_2  = POS_W'(32);
  localparam logic [POS_W-1:0] P_LON_MIN_HI = POS_W'(33);
  localparam logic [POS_W-1:0] P_LON_MIN_LO = POS_W'(34);
  localparam logic [POS_W-1:0] P_LON_DOT    = POS_W'(35);
  localparam logic [POS_W-1:0] P_LON_F1     = POS_W'(36);
  localparam logic [POS_W-1:0] P_LON_F2     = POS_W'(37);
  localparam logic [POS_W-1:0] P_LON_F3     = POS_W'(38);
  localparam logic [POS_W-1:0] P_LON_F4     = POS_W'(39);
  localparam logic [POS_W-1:0] P_LON_HEMI   = POS_W'(41);
  localparam logic [POS_W-1:0] P_SAT_HI     = POS_W'(45);
  localparam logic [POS_W-1:0] P_SAT_LO     = POS_W'(46);
  localparam logic [POS_W-1:0] P_MIN_CR     = POS_W'(47);
  localparam logic [POS_W-1:0] P_LAST       = POS_W'(MAX_FRAME - 1);

endpackage

### rtl/core/gga_if.sv
// received byte channel
interface gga_byte_if;
  logic                        valid;
  logic                        ready;
  logic [gga_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, rx_byte, input ready);
  modport sink (input valid, rx_byte, output ready);
endinterface

// decoded fix channel
interface gga_fix_if;
  logic                        valid;
  logic                        ready;
  logic [gga_pkg::TWO_W-1:0]   fix_hour;
  logic [gga_pkg::TWO_W-1:0]   fix_minute;
  logic [gga_pkg::SEC_W-1:0]   fix_second_ms;
  logic [gga_pkg::TWO_W-1:0]   lat_degrees;
  logic [gga_pkg::TWO_W-1:0]   lat_minutes;
  logic [gga_pkg::ARCS_W-1:0]  lat_second_ms;
  logic [gga_pkg::BYTE_W-1:0]  lat_hemisphere;
  logic [gga_pkg::LOND_W-1:0]  lon_degrees;
  logic [gga_pkg::TWO_W-1:0]   lon_minutes;
  logic [gga_pkg::ARCS_W-1:0]  lon_second_ms;
  logic [gga_pkg::BYTE_W-1:0]  lon_hemisphere;
  logic [gga_pkg::TWO_W-1:0]   satellite_count;

  modport source (
    output valid, fix_hour, fix_minute, fix_second_ms, lat_degrees, lat_minutes,
           lat_second_ms, lat_hemisphere, lon_degrees, lon_minutes, lon_second_ms,
           lon_hemisphere, satellite_count,
    input  ready
  );
  modport sink (
    input  valid, fix_hour, fix_minute, fix_second_ms, lat_degrees, lat_minutes,
           lat_second_ms, lat_hemisphere, lon_degrees, lon_minutes, lon_second_ms,
           lon_hemisphere, satellite_count,
    output ready
  );
endinterface

### rtl/core/nmea_gga_sentence_parser_top.sv
// GGA sentence parser, one received byte per cycle.
// Throughput: one byte accepted every cycle; the fix register holds one result while
// bytes keep streaming, and input stalls only if a frame could end before it is taken.
// Output: the fix is registered and appears in the cycle after the CR byte of a valid frame is accepted.
// Reset: rst (synchronous) returns to hunting for '$' and empties the fix register.
module nmea_gga_sentence_parser_top (
  input  logic        clk,
  input  logic        rst,
  gga_byte_if.sink    rx,
  gga_fix_if.source   fix
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_BODY
  } phase_t;

  localparam int BW = gga_pkg::BYTE_W;
  localparam int PW = gga_pkg::POS_W;
  localparam int TW = gga_pkg::TWO_W;
  localparam int SW = gga_pkg::SEC_W;
  localparam int FW = gga_pkg::FRAC_W;
  localparam int LW = gga_pkg::LOND_W;
  localparam int AW = gga_pkg::ARCS_W;

  // expected header letter at positions one to five
  function automatic logic [BW-1:0] header_char(input logic [PW-1:0] p);
    logic [BW-1:0] c;
    c = gga_pkg::CH_G;
    if (p == gga_pkg::P_HDR_2) c = gga_pkg::CH_P;
    if (p == gga_pkg::P_HDR_5) c = gga_pkg::CH_A;
    return c;
  endfunction

  // hex digit decode: {ok, value}
  function automatic logic [4:0] hex_val(input logic [BW-1:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= gga_pkg::CH_ZERO && b <= gga_pkg::CH_NINE)
      r = {1'b1, 4'(b - gga_pkg::CH_ZERO)};
    else if (b >= gga_pkg::CH_UA && b <= gga_pkg::CH_UF)
      r = {1'b1, 4'(b - gga_pkg::CH_UA + 8'd10)};
    else if (b >= gga_pkg::CH_LA && b <= gga_pkg::CH_LF)
      r = {1'b1, 4'(b - gga_pkg::CH_LA + 8'd10)};
    return r;
  endfunction

  // parser state
  phase_t          phase, phase_next;
  logic [PW-1:0]   pos, pos_next;
  logic [BW-1:0]   xsum, xsum_next;
  logic [BW-1:0]   recent [3];
  logic [BW-1:0]   recent_next [3];
  logic            stopped, stopped_next;
  logic [TW-1:0]   hour_acc, hour_next;
  logic [TW-1:0]   minute_acc, minute_next;
  logic [SW-1:0]   second_acc, second_next;
  logic [TW-1:0]   lat_deg_acc, lat_deg_next;
  logic [TW-1:0]   lat_min_acc, lat_min_next;
  logic [FW-1:0]   lat_frac_acc, lat_frac_next;
  logic [BW-1:0]   lat_hemi, lat_hemi_next;
  logic [LW-1:0]   lon_deg_acc, lon_deg_next;
  logic [TW-1:0]   lon_min_acc, lon_min_next;
  logic [FW-1:0]   lon_frac_acc, lon_frac_next;
  logic [BW-1:0]   lon_hemi, lon_hemi_next;
  logic [TW-1:0]   sat_acc, sat_next;

  logic            rx_xfer;
  logic            emit;
  logic [BW-1:0]   b;
  logic [PW-1:0]   pos_inc;
  logic            is_digit;
  logic [3:0]      digit;
  logic            take;
  logic            push;
  logic [BW-1:0]   sum;
  logic [4:0]      hex_hi, hex_lo;
  logic [BW-1:0]   rx_sum;
  logic [SW-1:0]   lat_prod, lon_prod;

  // stall only when a frame end could produce a second result before the first is taken
  assign rx.ready = !(fix.valid && !fix.ready && phase == PH_BODY
                      && pos_inc >= gga_pkg::P_MIN_CR);
  assign rx_xfer  = rx.valid && rx.ready;

  assign b        = rx.rx_byte;
  assign pos_inc  = pos + PW'(1);
  assign is_digit = (b >= gga_pkg::CH_ZERO) && (b <= gga_pkg::CH_NINE);
  assign digit    = 4'(b - gga_pkg::CH_ZERO);
  assign take     = !stopped && is_digit;

  // checksum of the frame, minus the trailing "*hh" bytes
  assign sum    = xsum ^ recent[0] ^ recent[1] ^ recent[2];
  assign hex_hi = hex_val(recent[1]);
  assign hex_lo = hex_val(recent[0]);
  always_comb begin
    if (!hex_hi[4])
      rx_sum = '0;
    else if (!hex_lo[4])
      rx_sum = {4'd0, hex_hi[3:0]};
    else
      rx_sum = {hex_hi[3:0], hex_lo[3:0]};
  end

  // minute fraction to arc seconds in ms
  assign lat_prod = SW'(lat_frac_acc) * SW'(6);
  assign lon_prod = SW'(lon_frac_acc) * SW'(6);

  // next-state logic for one accepted byte
  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    xsum_next      = xsum;
    recent_next    = recent;
    stopped_next   = stopped;
    hour_next      = hour_acc;
    minute_next    = minute_acc;
    second_next    = second_acc;
    lat_deg_next   = lat_deg_acc;
    lat_min_next   = lat_min_acc;
    lat_frac_next  = lat_frac_acc;
    lat_hemi_next  = lat_hemi;
    lon_deg_next   = lon_deg_acc;
    lon_min_next   = lon_min_acc;
    lon_frac_next  = lon_frac_acc;
    lon_hemi_next  = lon_hemi;
    sat_next       = sat_acc;
    emit           = 1'b0;
    push           = 1'b0;

    if (rx_xfer) begin
      unique case (phase)
        PH_HUNT: begin
          if (b == gga_pkg::CH_DOLLAR) begin
            phase_next    = PH_HEADER;
            pos_next      = '0;
            xsum_next     = '0;
            recent_next   = '{default: '0};
            stopped_next  = 1'b0;
            hour_next     = '0;
            minute_next   = '0;
            second_next   = '0;
            lat_deg_next  = '0;
            lat_min_next  = '0;
            lat_frac_next = '0;
            lat_hemi_next = '0;
            lon_deg_next  = '0;
            lon_min_next  = '0;
            lon_frac_next = '0;
            lon_hemi_next = '0;
            sat_next      = '0;
          end
        end
        PH_HEADER: begin
          pos_next = pos_inc;
          if (b != header_char(pos_inc)) begin
            phase_next = PH_HUNT;
          end else begin
            push = 1'b1;
            if (pos_inc == gga_pkg::P_HDR_5) phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          pos_next = pos_inc;
          if (b == gga_pkg::CH_CR) begin
            phase_next = PH_HUNT;
            emit = (pos_inc >= gga_pkg::P_MIN_CR) && (rx_sum == sum);
          end else if (pos_inc >= gga_pkg::P_LAST) begin
            phase_next = PH_HUNT;
          end else begin
            push = 1'b1;
            // fixed-position field decode
            unique case (pos_inc)
              gga_pkg::P_HOUR_HI: begin
                stopped_next = !is_digit;
                if (is_digit) hour_next = TW'(hour_acc * TW'(10) + TW'(digit));
              end
              gga_pkg::P_HOUR_LO: begin
                if (take) hour_next = TW'(hour_acc * TW'(10) + TW'(digit));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_MIN_HI: begin
                stopped_next = !is_digit;
                if (is_digit) minute_next = TW'(minute_acc * TW'(10) + TW'(digit));
              end
              gga_pkg::P_MIN_LO: begin
                if (take) minute_next = TW'(minute_acc * TW'(10) + TW'(digit));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_SEC_HI: begin
                stopped_next = !is_digit;
                if (is_digit) second_next = SW'(second_acc * SW'(10) + SW'(digit));
              end
              gga_pkg::P_SEC_LO: begin
                if (take) second_next = SW'(second_acc * SW'(10) + SW'(digit));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_SEC_DOT: begin
                second_next = SW'(second_acc * SW'(1000));
                if (b != gga_pkg::CH_DOT) stopped_next = 1'b1;
              end
              gga_pkg::P_SEC_F1: begin
                if (take) second_next = SW'(second_acc + SW'(digit) * SW'(100));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_SEC_F2: begin
                if (take) second_next = SW'(second_acc + SW'(digit) * SW'(10));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_SEC_F3: begin
                if (take) second_next = SW'(second_acc + SW'(digit));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_LAT_DEG_HI: begin
                stopped_next = !is_digit;
                if (is_digit) lat_deg_next = TW'(lat_deg_acc * TW'(10) + TW'(digit));
              end
              gga_pkg::P_LAT_DEG_LO: begin
                if (take) lat_deg_next = TW'(lat_deg_acc * TW'(10) + TW'(digit));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_LAT_MIN_HI: begin
                stopped_next = !is_digit;
                if (is_digit) lat_min_next = TW'(lat_min_acc * TW'(10) + TW'(digit));
              end
              gga_pkg::P_LAT_MIN_LO: begin
                if (take) lat_min_next = TW'(lat_min_acc * TW'(10) + TW'(digit));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_LAT_DOT: stopped_next = (b != gga_pkg::CH_DOT);
              gga_pkg::P_LAT_F1: begin
                if (take) lat_frac_next = FW'(lat_frac_acc + FW'(digit) * FW'(1000));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_LAT_F2: begin
                if (take) lat_frac_next = FW'(lat_frac_acc + FW'(digit) * FW'(100));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_LAT_F3: begin
                if (take) lat_frac_next = FW'(lat_frac_acc + FW'(digit) * FW'(10));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_LAT_F4: begin
                if (take) lat_frac_next = FW'(lat_frac_acc + FW'(digit));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_LAT_HEMI: lat_hemi_next = b;
              gga_pkg::P_LON_DEG_0: begin
                stopped_next = !is_digit;
                if (is_digit) lon_deg_next = LW'(lon_deg_acc * LW'(10) + LW'(digit));
              end
              gga_pkg::P_LON_DEG_1, gga_pkg::P_LON_DEG_2: begin
                if (take) lon_deg_next = LW'(lon_deg_acc * LW'(10) + LW'(digit));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_LON_MIN_HI: begin
                stopped_next = !is_digit;
                if (is_digit) lon_min_next = TW'(lon_min_acc * TW'(10) + TW'(digit));
              end
              gga_pkg::P_LON_MIN_LO: begin
                if (take) lon_min_next = TW'(lon_min_acc * TW'(10) + TW'(digit));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_LON_DOT: stopped_next = (b != gga_pkg::CH_DOT);
              gga_pkg::P_LON_F1: begin
                if (take) lon_frac_next = FW'(lon_frac_acc + FW'(digit) * FW'(1000));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_LON_F2: begin
                if (take) lon_frac_next = FW'(lon_frac_acc + FW'(digit) * FW'(100));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_LON_F3: begin
                if (take) lon_frac_next = FW'(lon_frac_acc + FW'(digit) * FW'(10));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_LON_F4: begin
                if (take) lon_frac_next = FW'(lon_frac_acc + FW'(digit));
                else stopped_next = 1'b1;
              end
              gga_pkg::P_LON_HEMI: lon_hemi_next = b;
              gga_pkg::P_SAT_HI: begin
                stopped_next = !is_digit;
                if (is_digit) sat_next = TW'(sat_acc * TW'(10) + TW'(digit));
              end
              gga_pkg::P_SAT_LO: begin
                if (take) sat_next = TW'(sat_acc * TW'(10) + TW'(digit));
                else stopped_next = 1'b1;
              end
              default: ;
            endcase
          end
        end
        default: phase_next = PH_HUNT;
      endcase
    end

    // running checksum and last three bytes
    if (push) begin
      xsum_next      = xsum ^ b;
      recent_next[2] = recent[1];
      recent_next[1] = recent[0];
      recent_next[0] = b;
    end
  end

  // state and fix register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      fix.valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (emit)
        fix.valid <= 1'b1;
      else if (fix.ready)
        fix.valid <= 1'b0;
    end

    pos          <= pos_next;
    xsum         <= xsum_next;
    recent       <= recent_next;
    stopped      <= stopped_next;
    hour_acc     <= hour_next;
    minute_acc   <= minute_next;
    second_acc   <= second_next;
    lat_deg_acc  <= lat_deg_next;
    lat_min_acc  <= lat_min_next;
    lat_frac_acc <= lat_frac_next;
    lat_hemi     <= lat_hemi_next;
    lon_deg_acc  <= lon_deg_next;
    lon_min_acc  <= lon_min_next;
    lon_frac_acc <= lon_frac_next;
    lon_hemi     <= lon_hemi_next;
    sat_acc      <= sat_next;

    if (emit) begin
      fix.fix_hour        <= hour_acc;
      fix.fix_minute      <= minute_acc;
      fix.fix_second_ms   <= second_acc;
      fix.lat_degrees     <= lat_deg_acc;
      fix.lat_minutes     <= lat_min_acc;
      fix.lat_second_ms   <= lat_prod[AW-1:0];
      fix.lat_hemisphere  <= lat_hemi;
      fix.lon_degrees     <= lon_deg_acc;
      fix.lon_minutes     <= lon_min_acc;
      fix.lon_second_ms   <= lon_prod[AW-1:0];
      fix.lon_hemisphere  <= lon_hemi;
      fix.satellite_count <= sat_acc;
    end
  end

endmodule

### tb/nmea_gga_sentence_parser_top_tb.sv
module nmea_gga_sentence_parser_top_tb;
  import gga_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 5;
  localparam int IDLE_PCT       = 15;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_BYTES   = 450;
  localparam int RANDOM_FIXES   = 40;
  localparam int FRAME_CAP      = 160;
  localparam int STEADY_LEN     = 500;

  // parser phases for the predictor and checksum styles for the frame builder
  typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_BODY} parse_phase_e;
  typedef enum logic [1:0] {SUM_GOOD, SUM_WRONG, SUM_HI_ONLY, SUM_NONE} sum_mode_e;

  // one decoded fix
  typedef struct {
    logic [TWO_W-1:0]  fix_hour;
    logic [TWO_W-1:0]  fix_minute;
    logic [SEC_W-1:0]  fix_second_ms;
    logic [TWO_W-1:0]  lat_degrees;
    logic [TWO_W-1:0]  lat_minutes;
    logic [ARCS_W-1:0] lat_second_ms;
    logic [BYTE_W-1:0] lat_hemisphere;
    logic [LOND_W-1:0] lon_degrees;
    logic [TWO_W-1:0]  lon_minutes;
    logic [ARCS_W-1:0] lon_second_ms;
    logic [BYTE_W-1:0] lon_hemisphere;
    logic [TWO_W-1:0]  satellite_count;
  } fix_t;

  // character classes shared by the predictor and the frame builder
  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // {valid, value} of one hex character
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return {1'b1, 4'(b - CH_ZERO)};
    if (b >= CH_UA && b <= CH_UF) return {1'b1, 4'(b - CH_UA + 8'd10)};
    if (b >= CH_LA && b <= CH_LF) return {1'b1, 4'(b - CH_LA + 8'd10)};
    return 5'b0;
  endfunction

  // predicts fixes from the byte stream and compares them with the block
  class gga_fix_scoreboard;
    parse_phase_e      phase;
    int unsigned       pos;
    logic [7:0]        sum_acc;
    logic [7:0]        last0, last1, last2;
    bit                stopped;
    logic [TWO_W-1:0]  hour, minute, lat_deg, lat_min, lon_min, sats;
    logic [SEC_W-1:0]  sec_ms;
    logic [FRAC_W-1:0] lat_frac, lon_frac;
    logic [LOND_W-1:0] lon_deg;
    logic [BYTE_W-1:0] lat_hemi, lon_hemi;
    fix_t              expected_fixes[$];
    int unsigned       errors;
    int unsigned       fixes_seen;

    function new();
      start_frame();
      errors = 0;
      fixes_seen = 0;
    endfunction

    function void start_frame();
      phase = PH_HUNT;
      pos = 0;
      sum_acc = '0;
      last0 = '0;
      last1 = '0;
      last2 = '0;
      stopped = 1'b0;
      hour = '0; minute = '0; sec_ms = '0;
      lat_deg = '0; lat_min = '0; lat_frac = '0; lat_hemi = '0;
      lon_deg = '0; lon_min = '0; lon_frac = '0; lon_hemi = '0;
      sats = '0;
    endfunction

    function int unsigned pending();
      return expected_fixes.size();
    endfunction

    // multiply-by-ten digit, a non-digit closes the field
    function int unsigned int_digit(input int unsigned acc, input logic [7:0] b);
      if (!stopped && is_digit(b)) return acc * 10 + (b - CH_ZERO);
      stopped = 1'b1;
      return acc;
    endfunction

    function int unsigned frac_digit(input int unsigned acc, input int unsigned weight,
                                     input logic [7:0] b);
      if (!stopped && is_digit(b)) return acc + (b - CH_ZERO) * weight;
      stopped = 1'b1;
      return acc;
    endfunction

    function logic [7:0] header_char(input int unsigned p);
      case (p)
        P_HDR_2: return CH_P;
        P_HDR_5: return CH_A;
        default: return CH_G;
      endcase
    endfunction

    function void shift_in(input logic [7:0] b);
      sum_acc ^= b;
      last2 = last1;
      last1 = last0;
      last0 = b;
    endfunction

    // fixed-position field decode
    function void decode_at(input int unsigned p, input logic [7:0] b);
      case (p)
        P_HOUR_HI:    begin stopped = 1'b0; hour = TWO_W'(int_digit(hour, b)); end
        P_HOUR_LO:    hour = TWO_W'(int_digit(hour, b));
        P_MIN_HI:     begin stopped = 1'b0; minute = TWO_W'(int_digit(minute, b)); end
        P_MIN_LO:     minute = TWO_W'(int_digit(minute, b));
        P_SEC_HI:     begin stopped = 1'b0; sec_ms = SEC_W'(int_digit(sec_ms, b)); end
        P_SEC_LO:     sec_ms = SEC_W'(int_digit(sec_ms, b));
        P_SEC_DOT: begin
          sec_ms = SEC_W'(sec_ms * 1000);
          if (b != CH_DOT) stopped = 1'b1;
        end
        P_SEC_F1:     sec_ms = SEC_W'(frac_digit(sec_ms, 100, b));
        P_SEC_F2:     sec_ms = SEC_W'(frac_digit(sec_ms, 10, b));
        P_SEC_F3:     sec_ms = SEC_W'(frac_digit(sec_ms, 1, b));
        P_LAT_DEG_HI: begin stopped = 1'b0; lat_deg = TWO_W'(int_digit(lat_deg, b)); end
        P_LAT_DEG_LO: lat_deg = TWO_W'(int_digit(lat_deg, b));
        P_LAT_MIN_HI: begin stopped = 1'b0; lat_min = TWO_W'(int_digit(lat_min, b)); end
        P_LAT_MIN_LO: lat_min = TWO_W'(int_digit(lat_min, b));
        P_LAT_DOT:    stopped = (b != CH_DOT);
        P_LAT_F1:     lat_frac = FRAC_W'(frac_digit(lat_frac, 1000, b));
        P_LAT_F2:     lat_frac = FRAC_W'(frac_digit(lat_frac, 100, b));
        P_LAT_F3:     lat_frac = FRAC_W'(frac_digit(lat_frac, 10, b));
        P_LAT_F4:     lat_frac = FRAC_W'(frac_digit(lat_frac, 1, b));
        P_LAT_HEMI:   lat_hemi = b;
        P_LON_DEG_0:  begin stopped = 1'b0; lon_deg = LOND_W'(int_digit(lon_deg, b)); end
        P_LON_DEG_1:  lon_deg = LOND_W'(int_digit(lon_deg, b));
        P_LON_DEG_2:  lon_deg = LOND_W'(int_digit(lon_deg, b));
        P_LON_MIN_HI: begin stopped = 1'b0; lon_min = TWO_W'(int_digit(lon_min, b)); end
        P_LON_MIN_LO: lon_min = TWO_W'(int_digit(lon_min, b));
        P_LON_DOT:    stopped = (b != CH_DOT);
        P_LON_F1:     lon_frac = FRAC_W'(frac_digit(lon_frac, 1000, b));
        P_LON_F2:     lon_frac = FRAC_W'(frac_digit(lon_frac, 100, b));
        P_LON_F3:     lon_frac = FRAC_W'(frac_digit(lon_frac, 10, b));
        P_LON_F4:     lon_frac = FRAC_W'(frac_digit(lon_frac, 1, b));
        P_LON_HEMI:   lon_hemi = b;
        P_SAT_HI:     begin stopped = 1'b0; sats = TWO_W'(int_digit(sats, b)); end
        P_SAT_LO:     sats = TWO_W'(int_digit(sats, b));
        default: ;
      endcase
    endfunction

    // checksum test at the CR, queue a fix when it holds
    function void close_frame();
      logic [7:0] sum;
      logic [7:0] rx_sum;
      logic [4:0] hi, lo;
      fix_t       f;
      sum = sum_acc ^ last0 ^ last1 ^ last2;
      hi = hex_nibble(last1);
      lo = hex_nibble(last0);
      if (!hi[4]) rx_sum = 8'h00;
      else if (!lo[4]) rx_sum = {4'h0, hi[3:0]};
      else rx_sum = {hi[3:0], lo[3:0]};
      if (rx_sum != sum) return;
      f.fix_hour        = hour;
      f.fix_minute      = minute;
      f.fix_second_ms   = sec_ms;
      f.lat_degrees     = lat_deg;
      f.lat_minutes     = lat_min;
      f.lat_second_ms   = ARCS_W'(lat_frac * 6);
      f.lat_hemisphere  = lat_hemi;
      f.lon_degrees     = lon_deg;
      f.lon_minutes     = lon_min;
      f.lon_second_ms   = ARCS_W'(lon_frac * 6);
      f.lon_hemisphere  = lon_hemi;
      f.satellite_count = sats;
      expected_fixes.push_back(f);
    endfunction

    // one accepted byte
    function void note_byte(input logic [7:0] b);
      if (phase == PH_HUNT) begin
        if (b == CH_DOLLAR) begin
          start_frame();
          phase = PH_HEADER;
        end
        return;
      end
      pos++;
      if (phase == PH_HEADER) begin
        if (pos < P_HDR_1 || pos > P_HDR_5 || b != header_char(pos)) begin
          phase = PH_HUNT;
          return;
        end
        shift_in(b);
        if (pos == P_HDR_5) phase = PH_BODY;
        return;
      end
      if (b == CH_CR) begin
        phase = PH_HUNT;
        if (pos >= P_MIN_CR) close_frame();
        return;
      end
      if (pos >= P_LAST) begin
        phase = PH_HUNT;
        return;
      end
      shift_in(b);
      decode_at(pos, b);
    endfunction

    function void compare(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
        $display("%0t: fix field %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // one fix transfer from the block
    function void check_fix(input fix_t got);
      fix_t want;
      if (expected_fixes.size() == 0) begin
        $display("%0t: unexpected fix, expected none, actual hour %0d minute %0d sats %0d",
                 $time, got.fix_hour, got.fix_minute, got.satellite_count);
        errors++;
        return;
      end
      want = expected_fixes.pop_front();
      fixes_seen++;
      compare("fix_hour", want.fix_hour, got.fix_hour);
      compare("fix_minute", want.fix_minute, got.fix_minute);
      compare("fix_second_ms", want.fix_second_ms, got.fix_second_ms);
      compare("lat_degrees", want.lat_degrees, got.lat_degrees);
      compare("lat_minutes", want.lat_minutes, got.lat_minutes);
      compare("lat_second_ms", want.lat_second_ms, got.lat_second_ms);
      compare("lat_hemisphere", want.lat_hemisphere, got.lat_hemisphere);
      compare("lon_degrees", want.lon_degrees, got.lon_degrees);
      compare("lon_minutes", want.lon_minutes, got.lon_minutes);
      compare("lon_second_ms", want.lon_second_ms, got.lon_second_ms);
      compare("lon_hemisphere", want.lon_hemisphere, got.lon_hemisphere);
      compare("satellite_count", want.satellite_count, got.satellite_count);
    endfunction
  endclass

  logic clk;
  logic rst;

  gga_byte_if rx_if ();
  gga_fix_if  fix_if ();

  nmea_gga_sentence_parser_top i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .fix (fix_if)
  );

  gga_fix_scoreboard sb = new();

  logic [7:0] frame_buf [0:FRAME_CAP-1];
  logic [7:0] byte_stream[$];
  int         junk_pct;
  int         good_frames;
  int         frames_built;
  int         directed_bytes;
  int         bytes_sent;
  int         hold_at = 32'h7fff_ffff;
  int         steady_lo = 32'h7fff_ffff;
  bit         hold_done;
  int         idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------- frame builder ----------------

  function automatic logic [7:0] not_cr_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
    return b;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do b = not_cr_byte(); while (hex_nibble(b) >= 5'h10);
    return b;
  endfunction

  // printable padding, never a dollar so dropped tails stay quiet
  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'h7e)); while (b == CH_DOLLAR);
    return b;
  endfunction

  function automatic logic [7:0] digit_char();
    if ($urandom_range(0, 99) < junk_pct) return not_cr_byte();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] dot_char();
    if ($urandom_range(0, 99) < junk_pct) return not_cr_byte();
    return CH_DOT;
  endfunction

  function automatic logic [7:0] hemi_char(input logic [7:0] a, input logic [7:0] b);
    if ($urandom_range(0, 9) == 0) return not_cr_byte();
    return $urandom_range(0, 1) ? a : b;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 10) return CH_ZERO + 8'(v);
    return (lower ? CH_LA : CH_UA) + 8'(v) - 8'd10;
  endfunction

  task automatic put_text(input int at, input string s);
    int k;
    for (k = 0; k < s.len(); k++) frame_buf[at + k] = s[k];
  endtask

  // random fields at the standard layout, padding after the sat count
  task automatic fill_frame();
    int k;
    for (k = 0; k < FRAME_CAP; k++) frame_buf[k] = filler_byte();
    put_text(0, "$GPGGA,");
    for (k = P_HOUR_HI; k <= P_SAT_LO; k++) frame_buf[k] = digit_char();
    frame_buf[P_SEC_DOT]       = dot_char();
    frame_buf[P_SEC_F3 + 1]    = ",";
    frame_buf[P_LAT_DOT]       = dot_char();
    frame_buf[P_LAT_F4 + 1]    = ",";
    frame_buf[P_LAT_HEMI]      = hemi_char("N", "S");
    frame_buf[P_LAT_HEMI + 1]  = ",";
    frame_buf[P_LON_DOT]       = dot_char();
    frame_buf[P_LON_F4 + 1]    = ",";
    frame_buf[P_LON_HEMI]      = hemi_char("E", "W");
    frame_buf[P_LON_HEMI + 1]  = ",";
    frame_buf[P_SAT_HI - 1]    = ",";
  endtask

  task automatic push_span(input int n);
    int k;
    for (k = 0; k < n; k++) byte_stream.push_back(frame_buf[k]);
    frames_built++;
  endtask

  // xor over the summed bytes except position 6, which serves as a trim byte
  function automatic logic [7:0] body_xor(input int cr_pos);
    logic [7:0] x;
    int         k;
    x = '0;
    for (k = 1; k <= cr_pos - 4; k++) if (k != 6) x ^= frame_buf[k];
    return x;
  endfunction

  // checksum trio and CR, then queue the frame
  task automatic seal_frame(input int cr_pos, input sum_mode_e mode, input bit lower,
                            input logic [7:0] star);
    logic [7:0] part, target, hi, lo;
    if (mode == SUM_HI_ONLY || mode == SUM_NONE) begin
      target = (mode == SUM_HI_ONLY) ? 8'($urandom_range(0, 15)) : 8'h00;
      part = body_xor(cr_pos);
      while ((part ^ target) == CH_CR) begin
        frame_buf[P_SEC_F3 + 1] = not_cr_byte();
        part = body_xor(cr_pos);
      end
      frame_buf[6] = part ^ target;
    end else begin
      target = body_xor(cr_pos) ^ frame_buf[6];
      if (mode == SUM_WRONG) target ^= 8'($urandom_range(1, 255));
    end
    frame_buf[cr_pos - 3] = star;
    case (mode)
      SUM_HI_ONLY: begin
        hi = hex_char(target[3:0], lower);
        lo = non_hex_byte();
      end
      SUM_NONE: begin
        hi = non_hex_byte();
        lo = not_cr_byte();
      end
      default: begin
        hi = hex_char(target[7:4], lower);
        lo = hex_char(target[3:0], lower);
      end
    endcase
    frame_buf[cr_pos - 2] = hi;
    frame_buf[cr_pos - 1] = lo;
    frame_buf[cr_pos]     = CH_CR;
    push_span(cr_pos + 1);
  endtask

  task automatic build_directed();
    junk_pct = 0;
    // largest digits, raw hemisphere extremes
    fill_frame();
    put_text(P_HOUR_HI, "999999.999");
    put_text(P_LAT_DEG_HI, "9999.9999");
    put_text(P_LON_DEG_0, "99999.9999");
    put_text(P_SAT_HI, "99");
    frame_buf[P_LAT_HEMI] = 8'hff;
    frame_buf[P_LON_HEMI] = 8'h00;
    seal_frame(60, SUM_GOOD, 1'b0, "*");
    // all zeros, lower case checksum
    fill_frame();
    put_text(P_HOUR_HI, "000000.000");
    put_text(P_LAT_DEG_HI, "0000.0000");
    put_text(P_LON_DEG_0, "00000.0000");
    put_text(P_SAT_HI, "00");
    frame_buf[P_LAT_HEMI] = "S";
    frame_buf[P_LON_HEMI] = "W";
    seal_frame(55, SUM_GOOD, 1'b1, "*");
    // shortest accepted frame, then one byte too short
    fill_frame();
    seal_frame(P_MIN_CR, SUM_GOOD, 1'b0, "*");
    fill_frame();
    seal_frame(P_MIN_CR - 1, SUM_GOOD, 1'b0, "*");
    // longest frame, then one that runs past the buffer
    fill_frame();
    seal_frame(P_LAST, SUM_GOOD, 1'b1, "*");
    fill_frame();
    push_span(MAX_FRAME + 2);
    // a second dollar in the header slot is not a new start
    byte_stream.push_back(CH_DOLLAR);
    fill_frame();
    seal_frame(52, SUM_GOOD, 1'b0, "*");
    // wrong header letter
    fill_frame();
    frame_buf[P_HDR_4] = "S";
    seal_frame(52, SUM_GOOD, 1'b0, "*");
    // space, sign and dollar end fields early, dollar in the padding too
    fill_frame();
    put_text(P_HOUR_HI, " 13$");
    put_text(P_LAT_DEG_HI, "-4");
    frame_buf[50] = CH_DOLLAR;
    seal_frame(60, SUM_GOOD, 1'b0, "*");
    // missing dots before each fraction
    fill_frame();
    frame_buf[P_SEC_DOT] = ",";
    frame_buf[P_LAT_DOT] = " ";
    frame_buf[P_LON_DOT] = "x";
    seal_frame(58, SUM_GOOD, 1'b0, "*");
    // junk in seconds integer carries over the dot, junk inside a fraction
    fill_frame();
    put_text(P_SEC_HI, "1a.456");
    put_text(P_LAT_MIN_HI, "5,.12x4");
    seal_frame(58, SUM_GOOD, 1'b0, "*");
    // empty fields
    fill_frame();
    put_text(P_HOUR_HI, ",,,,,,,,,,,");
    put_text(P_LAT_DEG_HI, ",,,,,,,,,,,");
    put_text(P_SAT_HI, ",,");
    seal_frame(54, SUM_GOOD, 1'b0, "*");
    // checksum with one digit, none, a wrong one, and a non-star marker
    fill_frame();
    seal_frame(56, SUM_HI_ONLY, 1'b1, "*");
    fill_frame();
    seal_frame(56, SUM_NONE, 1'b0, "*");
    fill_frame();
    seal_frame(56, SUM_WRONG, 1'b0, "*");
    fill_frame();
    seal_frame(56, SUM_GOOD, 1'b0, "Q");
    // line noise before the frame, bare header then CR
    repeat (5) byte_stream.push_back(filler_byte());
    fill_frame();
    seal_frame(64, SUM_GOOD, 1'b0, "*");
    byte_stream.push_back(CH_DOLLAR);
    put_text(0, "$GPGGA");
    frame_buf[6] = CH_CR;
    push_span(7);
  endtask

  function automatic int pick_length();
    int v;
    v = $urandom_range(0, 99);
    if (v < 80) return $urandom_range(P_MIN_CR, 70);
    if (v < 95) return $urandom_range(71, P_LAST - 1);
    return P_LAST;
  endfunction

  function automatic sum_mode_e pick_mode();
    int v;
    v = $urandom_range(0, 99);
    if (v < 90) return SUM_GOOD;
    if (v < 95) return SUM_HI_ONLY;
    return SUM_NONE;
  endfunction

  // mostly well-formed frames, the rest broken frames and noise
  task automatic build_random();
    int r;
    while (byte_stream.size() - directed_bytes < RANDOM_BYTES || good_frames < RANDOM_FIXES) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) byte_stream.push_back(8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      junk_pct = ($urandom_range(0, 3) == 0) ? 3 : 0;
      fill_frame();
      if (r < 70) begin
        seal_frame(pick_length(), pick_mode(), 1'($urandom_range(0, 1)), "*");
        good_frames++;
      end else if (r < 78) begin
        seal_frame(pick_length(), SUM_WRONG, 1'($urandom_range(0, 1)), "*");
      end else if (r < 84) begin
        frame_buf[$urandom_range(P_HDR_1, P_HDR_5)] = not_cr_byte();
        seal_frame(pick_length(), SUM_GOOD, 1'b0, "*");
      end else if (r < 90) begin
        seal_frame($urandom_range(8, P_MIN_CR - 1), SUM_GOOD, 1'b0, "*");
      end else if (r < 94) begin
        push_span($urandom_range(MAX_FRAME, MAX_FRAME + 12));
      end else begin
        junk_pct = 30;
        fill_frame();
        seal_frame(pick_length(), SUM_GOOD, 1'b0, "*");
      end
    end
  endtask

  // ---------------- drivers ----------------

  function automatic bit in_steady();
    return bytes_sent >= steady_lo && bytes_sent < steady_lo + STEADY_LEN;
  endfunction

  // byte source, one transfer per stream entry
  task automatic stream_bytes();
    int i;
    for (i = 0; i < byte_stream.size(); i++) begin
      while (!in_steady() && $urandom_range(0, 99) < IDLE_PCT) begin
        rx_if.valid <= 1'b0;
        @(negedge clk);
      end
      rx_if.valid   <= 1'b1;
      rx_if.rx_byte <= byte_stream[i];
      @(posedge clk);
      while (!rx_if.ready) @(posedge clk);
      sb.note_byte(byte_stream[i]);
      bytes_sent++;
      @(negedge clk);
    end
    rx_if.valid <= 1'b0;
  endtask

  // fix sink with random stalls and one long hold-off
  initial begin
    fix_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && bytes_sent >= hold_at) begin
        fix_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      fix_if.ready <= in_steady() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // fix transfer check
  always @(posedge clk) begin
    fix_t got;
    if (!rst && fix_if.valid && fix_if.ready) begin
      got.fix_hour        = fix_if.fix_hour;
      got.fix_minute      = fix_if.fix_minute;
      got.fix_second_ms   = fix_if.fix_second_ms;
      got.lat_degrees     = fix_if.lat_degrees;
      got.lat_minutes     = fix_if.lat_minutes;
      got.lat_second_ms   = fix_if.lat_second_ms;
      got.lat_hemisphere  = fix_if.lat_hemisphere;
      got.lon_degrees     = fix_if.lon_degrees;
      got.lon_minutes     = fix_if.lon_minutes;
      got.lon_second_ms   = fix_if.lon_second_ms;
      got.lon_hemisphere  = fix_if.lon_hemisphere;
      got.satellite_count = fix_if.satellite_count;
      sb.check_fix(got);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (fix_if.valid && fix_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d fixes still expected",
               $time, idle_cycles, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst           = 1'b1;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    build_directed();
    directed_bytes = byte_stream.size();
    build_random();
    hold_at   = directed_bytes + 150;
    steady_lo = directed_bytes + 700;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    stream_bytes();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("streamed %0d bytes in %0d frames (%0d well-formed), compared %0d fixes",
             bytes_sent, frames_built, good_frames, sb.fixes_seen);
    $display("receiver hold-off of %0d cycles backed up the input, %0d mismatches",
             HOLD_CYCLES, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
